// ----- rtl/core/rgbyuv_pkg.sv -----
package rgbyuv_pkg;

  // Default size limits of the source image.
  localparam int unsigned MaxWidthDefault  = 4096;
  localparam int unsigned MaxHeightDefault = 4096;

  // Configuration register file.
  localparam int unsigned CfgDataWidth  = 13;
  localparam int unsigned CfgIndexWidth = 1;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [CfgDataWidth-1:0] ImageWidthReset  = 13'd640;
  localparam logic [CfgDataWidth-1:0] ImageHeightReset = 13'd480;

  // Color conversion coefficients, scaled by 2^16 and rounded.
  localparam int unsigned AccWidth = 26;

  localparam logic signed [AccWidth-1:0] CoefYR = 26'sd19595;
  localparam logic signed [AccWidth-1:0] CoefYG = 26'sd38470;
  localparam logic signed [AccWidth-1:0] CoefYB = 26'sd7471;
  localparam logic signed [AccWidth-1:0] CoefUR = -26'sd9642;
  localparam logic signed [AccWidth-1:0] CoefUG = -26'sd18931;
  localparam logic signed [AccWidth-1:0] CoefUB = 26'sd28574;
  localparam logic signed [AccWidth-1:0] CoefVR = 26'sd40305;
  localparam logic signed [AccWidth-1:0] CoefVG = -26'sd33750;
  localparam logic signed [AccWidth-1:0] CoefVB = -26'sd6554;
  localparam logic signed [AccWidth-1:0] OffsetLuma   = 26'sd0;
  localparam logic signed [AccWidth-1:0] OffsetChroma = 26'sd8388608;

  // Each line memory word carries the U sum and the V sum of one pair.
  localparam int unsigned SumWidth     = 9;
  localparam int unsigned LineSumWidth = 2 * SumWidth;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] u;
    logic [7:0] v;
  } yuv_t;

  // Raster position flags of one pixel.
  typedef struct packed {
    logic col_odd;
    logic row_odd;
    logic last_col;
    logic last_row;
  } pos_t;

  // One output channel of the conversion: weighted sum, floor, clamp to 0..255.
  function automatic logic [7:0] csc_channel(
    input logic [7:0]                 r,
    input logic [7:0]                 g,
    input logic [7:0]                 b,
    input logic signed [AccWidth-1:0] cr,
    input logic signed [AccWidth-1:0] cg,
    input logic signed [AccWidth-1:0] cb,
    input logic signed [AccWidth-1:0] offset
  );
    logic signed [AccWidth-1:0] acc;
    logic [8:0]                 whole;
    logic [7:0]                 result;
    acc = $signed({18'b0, r}) * cr + $signed({18'b0, g}) * cg
        + $signed({18'b0, b}) * cb + offset;
    whole = acc[24:16];
    if (acc[AccWidth-1]) begin
      result = 8'd0;
    end else if (whole[8]) begin
      result = 8'hFF;
    end else begin
      result = whole[7:0];
    end
    return result;
  endfunction

endpackage

// ----- rtl/core/rgbyuv_ram.sv -----
module rgbyuv_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrWidth-1:0]     waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AddrWidth-1:0]     raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rgbyuv_position.sv -----
module rgbyuv_position #(
  parameter int unsigned MAX_WIDTH  = rgbyuv_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = rgbyuv_pkg::MaxHeightDefault,
  localparam int unsigned PairSlots = (MAX_WIDTH + 1) / 2,
  localparam int unsigned SlotWidth = (PairSlots > 1) ? $clog2(PairSlots) : 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [rgbyuv_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [rgbyuv_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                   advance_i,
  output rgbyuv_pkg::pos_t                       pos_o,
  output logic [SlotWidth-1:0]                   slot_o
);

  localparam int unsigned ColWidth  = $clog2(MAX_WIDTH);
  localparam int unsigned RowWidth  = $clog2(MAX_HEIGHT);
  localparam int unsigned DimWWidth = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DimHWidth = $clog2(MAX_HEIGHT + 1);

  logic [rgbyuv_pkg::CfgDataWidth-1:0] width_q, height_q;
  logic [ColWidth-1:0]                 col_q, col;
  logic [RowWidth-1:0]                 row_q, row;
  logic [RowWidth:0]                   row_inc;
  logic [DimWWidth-1:0]                w_eff;
  logic [DimHWidth-1:0]                h_eff;
  logic                                col_wrap, last_col, last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rgbyuv_pkg::ImageWidthReset;
      height_q <= rgbyuv_pkg::ImageHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rgbyuv_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        rgbyuv_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero dimension acts as one; an oversized one saturates.
  always_comb begin
    if (width_q == '0) begin
      w_eff = DimWWidth'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = DimWWidth'(MAX_WIDTH);
    end else begin
      w_eff = DimWWidth'(width_q);
    end
    if (height_q == '0) begin
      h_eff = DimHWidth'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = DimHWidth'(MAX_HEIGHT);
    end else begin
      h_eff = DimHWidth'(height_q);
    end
  end

  // Counters left out of range by a dimension change wrap before use.
  always_comb begin
    col_wrap = 32'(col_q) >= 32'(w_eff);
    col      = col_wrap ? '0 : col_q;
    row_inc  = col_wrap ? ({1'b0, row_q} + 1'b1) : {1'b0, row_q};
    row      = (32'(row_inc) >= 32'(h_eff)) ? '0 : row_inc[RowWidth-1:0];
    last_col = 32'(col) == 32'(w_eff) - 32'd1;
    last_row = 32'(row) == 32'(h_eff) - 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row + 1'b1;
      end else begin
        col_q <= col + 1'b1;
        row_q <= row;
      end
    end
  end

  assign pos_o.col_odd  = col[0];
  assign pos_o.row_odd  = row[0];
  assign pos_o.last_col = last_col;
  assign pos_o.last_row = last_row;
  assign slot_o         = SlotWidth'(col >> 1);

endmodule

// ----- rtl/core/rgbyuv_csc.sv -----
module rgbyuv_csc #(
  parameter int unsigned MAX_WIDTH = rgbyuv_pkg::MaxWidthDefault,
  localparam int unsigned PairSlots = (MAX_WIDTH + 1) / 2,
  localparam int unsigned SlotWidth = (PairSlots > 1) ? $clog2(PairSlots) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic                  valid_i,
  input  rgbyuv_pkg::pixel_t    pix_i,
  input  rgbyuv_pkg::pos_t      pos_i,
  input  logic [SlotWidth-1:0]  slot_i,
  output logic                  valid_o,
  output rgbyuv_pkg::yuv_t      yuv_o,
  output rgbyuv_pkg::pos_t      pos_o,
  output logic [SlotWidth-1:0]  slot_o
);

  logic                 valid_q;
  rgbyuv_pkg::yuv_t     yuv_d, yuv_q;
  rgbyuv_pkg::pos_t     pos_q;
  logic [SlotWidth-1:0] slot_q;

  always_comb begin
    yuv_d.luma = rgbyuv_pkg::csc_channel(pix_i.red, pix_i.green, pix_i.blue,
      rgbyuv_pkg::CoefYR, rgbyuv_pkg::CoefYG, rgbyuv_pkg::CoefYB, rgbyuv_pkg::OffsetLuma);
    yuv_d.u    = rgbyuv_pkg::csc_channel(pix_i.red, pix_i.green, pix_i.blue,
      rgbyuv_pkg::CoefUR, rgbyuv_pkg::CoefUG, rgbyuv_pkg::CoefUB, rgbyuv_pkg::OffsetChroma);
    yuv_d.v    = rgbyuv_pkg::csc_channel(pix_i.red, pix_i.green, pix_i.blue,
      rgbyuv_pkg::CoefVR, rgbyuv_pkg::CoefVG, rgbyuv_pkg::CoefVB, rgbyuv_pkg::OffsetChroma);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      yuv_q  <= yuv_d;
      pos_q  <= pos_i;
      slot_q <= slot_i;
    end
  end

  assign valid_o = valid_q;
  assign yuv_o   = yuv_q;
  assign pos_o   = pos_q;
  assign slot_o  = slot_q;

endmodule

// ----- rtl/core/rgbyuv_chroma.sv -----
module rgbyuv_chroma #(
  parameter int unsigned MAX_WIDTH = rgbyuv_pkg::MaxWidthDefault,
  localparam int unsigned PairSlots = (MAX_WIDTH + 1) / 2,
  localparam int unsigned SlotWidth = (PairSlots > 1) ? $clog2(PairSlots) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  rgbyuv_pkg::yuv_t      yuv_i,
  input  rgbyuv_pkg::pos_t      pos_i,
  input  logic [SlotWidth-1:0]  slot_i,
  input  logic                  rd_en_i,
  input  logic [SlotWidth-1:0]  rd_slot_i,
  input  logic                  out_ready_i,
  output logic                  out_load_o,
  output logic                  out_valid_o,
  output rgbyuv_pkg::result_t   out_data_o
);

  localparam int unsigned SumW      = rgbyuv_pkg::SumWidth;
  localparam int unsigned LineW     = rgbyuv_pkg::LineSumWidth;

  logic                 out_valid_q, out_load, advance;
  rgbyuv_pkg::result_t  out_data_d, out_data_q;
  logic [7:0]           hold_u_q, hold_v_q;
  logic                 fwd_q;
  logic [LineW-1:0]     fwd_data_q, rdata, wdata;
  logic                 we;
  logic [SumW-1:0]      line_u, line_v, pair_u, pair_v, sum_u, sum_v;
  logic [SumW:0]        quad_u, quad_v, half_u, half_v;

  assign out_load = !out_valid_q || out_ready_i;
  assign advance  = valid_i && out_load;

  rgbyuv_ram #(
    .WIDTH (LineW),
    .DEPTH (PairSlots)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_i),
    .wdata_i (wdata),
    .re_i    (rd_en_i),
    .raddr_i (rd_slot_i),
    .rdata_o (rdata)
  );

  // A line sum written in the same cycle as it is read comes from the bypass.
  always_comb begin
    line_u = fwd_q ? fwd_data_q[LineW-1:SumW] : rdata[LineW-1:SumW];
    line_v = fwd_q ? fwd_data_q[SumW-1:0]     : rdata[SumW-1:0];
    pair_u = {1'b0, hold_u_q} + {1'b0, yuv_i.u};
    pair_v = {1'b0, hold_v_q} + {1'b0, yuv_i.v};
    sum_u  = pos_i.col_odd ? pair_u : {1'b0, yuv_i.u};
    sum_v  = pos_i.col_odd ? pair_v : {1'b0, yuv_i.v};
    quad_u = {1'b0, line_u} + {1'b0, pair_u};
    quad_v = {1'b0, line_v} + {1'b0, pair_v};
    half_u = {1'b0, line_u} + {2'b0, yuv_i.u};
    half_v = {1'b0, line_v} + {2'b0, yuv_i.v};
    wdata  = {sum_u, sum_v};
    we     = advance && !pos_i.row_odd && (pos_i.col_odd || pos_i.last_col)
             && !pos_i.last_row;

    out_data_d.luma         = yuv_i.luma;
    out_data_d.frame_end    = pos_i.last_col && pos_i.last_row;
    out_data_d.chroma_valid = 1'b0;
    out_data_d.chroma_u     = 8'd0;
    out_data_d.chroma_v     = 8'd0;
    if (!pos_i.row_odd) begin
      // Even row: the block only closes here on the bottom row.
      if ((pos_i.col_odd || pos_i.last_col) && pos_i.last_row) begin
        out_data_d.chroma_valid = 1'b1;
        out_data_d.chroma_u     = pos_i.col_odd ? sum_u[SumW-1:1] : sum_u[7:0];
        out_data_d.chroma_v     = pos_i.col_odd ? sum_v[SumW-1:1] : sum_v[7:0];
      end
    end else if (pos_i.col_odd) begin
      out_data_d.chroma_valid = 1'b1;
      out_data_d.chroma_u     = quad_u[SumW:2];
      out_data_d.chroma_v     = quad_v[SumW:2];
    end else if (pos_i.last_col) begin
      out_data_d.chroma_valid = 1'b1;
      out_data_d.chroma_u     = half_u[SumW-1:1];
      out_data_d.chroma_v     = half_v[SumW-1:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hold_u_q    <= 8'd0;
      hold_v_q    <= 8'd0;
      fwd_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= valid_i;
      end
      if (advance && !pos_i.col_odd) begin
        hold_u_q <= yuv_i.u;
        hold_v_q <= yuv_i.v;
      end
      if (rd_en_i) begin
        fwd_q <= we && (slot_i == rd_slot_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
    if (rd_en_i) begin
      fwd_data_q <= wdata;
    end
  end

  assign out_load_o  = out_load;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/rgb_to_yuv420_converter.sv -----
// Channel     | Direction | Handshake             | Payload
// ------------+-----------+-----------------------+---------------------------------------
// pixel in    | input     | in_valid_i/in_ready_o | in_data_i: red, green, blue
// result out  | output    | out_valid_o/out_ready_i | out_data_o: luma, chroma, frame_end
// config      | input     | cfg_we_i (no wait)    | cfg_index_i, cfg_data_i
//
// The block takes one pixel transaction per clock cycle while in_ready_o is high, and
// gives one result per pixel. After its pixel is accepted, a result passes the input
// register, the color conversion register and the result register.
// The line memory has one write and one read port; it is not cleared after reset and is
// filled by even rows before odd rows read it, so no clearing pass is needed.
// A stall at the output fills the three registers before in_ready_o falls.

module rgb_to_yuv420_converter #(
  parameter int unsigned MAX_WIDTH  = rgbyuv_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = rgbyuv_pkg::MaxHeightDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  rgbyuv_pkg::pixel_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output rgbyuv_pkg::result_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [rgbyuv_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [rgbyuv_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  localparam int unsigned PairSlots = (MAX_WIDTH + 1) / 2;
  localparam int unsigned SlotWidth = (PairSlots > 1) ? $clog2(PairSlots) : 1;

  // Stage handshake: each register loads when it is empty or its content moves on.
  logic                 s0_valid_q, s0_load, s1_load, s1_valid, out_load, accept;
  rgbyuv_pkg::pixel_t   s0_pix_q;
  rgbyuv_pkg::pos_t     pos, s0_pos_q, s1_pos;
  logic [SlotWidth-1:0] slot, s0_slot_q, s1_slot;
  rgbyuv_pkg::yuv_t     s1_yuv;
  logic                 rd_en;

  assign s1_load    = !s1_valid || out_load;
  assign s0_load    = !s0_valid_q || s1_load;
  assign in_ready_o = s0_load;
  assign accept     = in_valid_i && s0_load;

  // The line sum of a pixel is read as it moves into the conversion register,
  // so that it lines up with that pixel at the chroma stage.
  assign rd_en = s0_valid_q && s1_load;

  // Raster counters and configuration; the position is taken at acceptance.
  rgbyuv_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (accept),
    .pos_o       (pos),
    .slot_o      (slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_load) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_pix_q  <= in_data_i;
      s0_pos_q  <= pos;
      s0_slot_q <= slot;
    end
  end

  // Color conversion into Y, U and V, registered.
  rgbyuv_csc #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_csc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_load),
    .valid_i (s0_valid_q),
    .pix_i   (s0_pix_q),
    .pos_i   (s0_pos_q),
    .slot_i  (s0_slot_q),
    .valid_o (s1_valid),
    .yuv_o   (s1_yuv),
    .pos_o   (s1_pos),
    .slot_o  (s1_slot)
  );

  // Chroma averaging over 2x2 blocks, line memory and result register.
  rgbyuv_chroma #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_chroma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .yuv_i       (s1_yuv),
    .pos_i       (s1_pos),
    .slot_i      (s1_slot),
    .rd_en_i     (rd_en),
    .rd_slot_i   (s0_slot_q),
    .out_ready_i (out_ready_i),
    .out_load_o  (out_load),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/rgbyuv_checker.sv -----
module rgbyuv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rgbyuv_pkg::result_t out_data_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Chroma fields read zero on pixels that close no block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.chroma_valid |->
      out_data_o.chroma_u == 8'd0 && out_data_o.chroma_v == 8'd0)
    else $error("chroma without chroma_valid");

  // The last pixel of an image always closes a chroma block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.chroma_valid)
    else $error("frame end without chroma");

  // The input side never waits while the output side moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

endmodule

bind rgb_to_yuv420_converter rgbyuv_checker u_rgbyuv_checker (.*);
